// ----- rtl/cbfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel busy fraction estimator package
// Shared word types, command and status bundles, codes and constants.
// ----------------------------------------------------------------------------
package cbfe_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QUO_WIDTH = FRAC_BITS + 1;
   localparam int TOTAL_WIDTH = 24;
   localparam int ADDR_WIDTH = 4;
   localparam int DATA_WIDTH = 32;
   localparam int STEP_WIDTH = 5;

   localparam logic [QUO_WIDTH-1:0] FRAC_ONE = 17'h10000;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = 24'hFFFFFF;
   localparam logic [STEP_WIDTH-1:0] STEP_LAST = 5'(QUO_WIDTH - 1);

   localparam logic signed [11:0] THRESHOLD_RESET = -12'sd280;
   localparam logic [15:0] WINDOW_RESET = 16'd1000;
   localparam logic REPORT_RESET = 1'b0;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] REG_BUSY_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_WINDOW_MS = 2'd1;
   localparam logic [1:0] REG_REPORT_ENABLE = 2'd2;

   typedef struct packed {
      logic op;
      logic signed [11:0] rssi;
   } req_type;

   typedef struct packed {
      logic [16:0] busy_fraction;
      logic empty_window;
      logic [23:0] sample_total;
   } rsp_type;

   typedef struct packed {
      logic signed [11:0] busy_threshold;
      logic [15:0] window_ms;
      logic report_enable;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic sample_en;
      logic tick_en;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic window_end;
      logic empty;
      logic out_valid;
   } status_type;

endpackage

// ----- rtl/cbfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel busy fraction estimator controller
// Sequences sample counting, window ends, the divider and the result load.
// ----------------------------------------------------------------------------
module cbfe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   input  logic                  rsp_ready,
   input  logic                  report_enable,
   input  cbfe_pkg::status_type  status,
   output logic                  req_ready,
   output cbfe_pkg::cmd_type     cmd
);

   cbfe_pkg::state_type state_ff, state_in;
   logic [cbfe_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic out_free;

   assign out_free = !status.out_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbfe_pkg::ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbfe_pkg::ST_IDLE: begin
            if (req_valid && req_op == cbfe_pkg::OP_TICK && status.window_end
                && report_enable) begin
               state_in = status.empty ? cbfe_pkg::ST_HOLD : cbfe_pkg::ST_DIVIDE;
            end
         end
         cbfe_pkg::ST_DIVIDE: begin
            if (step_ff == cbfe_pkg::STEP_LAST) begin
               state_in = cbfe_pkg::ST_HOLD;
            end
         end
         cbfe_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = cbfe_pkg::ST_IDLE;
            end
         end
         default: state_in = cbfe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      step_in = '0;
      if (state_ff == cbfe_pkg::ST_DIVIDE) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         cbfe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.sample_en = req_valid && req_op == cbfe_pkg::OP_SAMPLE;
            cmd.tick_en = req_valid && req_op == cbfe_pkg::OP_TICK;
         end
         cbfe_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         cbfe_pkg::ST_HOLD: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/cbfe_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel busy fraction estimator datapath
// Saturating counters, window countdown, serial divider and result register.
// ----------------------------------------------------------------------------
module cbfe_datapath #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cbfe_pkg::cmd_type     cmd,
   input  cbfe_pkg::cfg_type     cfg,
   input  logic signed [11:0]    rssi,
   input  logic                  rsp_ready,
   output cbfe_pkg::status_type  status,
   output logic                  rsp_valid,
   output cbfe_pkg::rsp_type     rsp_word
);

   localparam int NumWidth = COUNT_WIDTH + cbfe_pkg::QUO_WIDTH;
   localparam int QW = cbfe_pkg::QUO_WIDTH;

   logic [COUNT_WIDTH-1:0] busy_ff, busy_in;
   logic [COUNT_WIDTH-1:0] sample_ff, sample_in;
   logic [15:0] ms_ff, ms_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] div_ff, div_in;
   logic [QW-1:0] num_ff, num_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic empty_ff, empty_in;
   logic [23:0] total_ff, total_in;
   logic out_valid_ff, out_valid_in;
   cbfe_pkg::rsp_type out_ff, out_in;

   logic window_end;
   logic [NumWidth-1:0] numerator;
   logic [COUNT_WIDTH:0] trial;
   logic [COUNT_WIDTH:0] diff;
   logic [31:0] sample_wide;
   logic [23:0] total_sat;
   logic [QW-1:0] frac_clamped;

   assign window_end = ms_ff <= 16'd1;
   assign numerator = NumWidth'({busy_ff, cbfe_pkg::FRAC_BITS'(0)})
                    + NumWidth'(sample_ff >> 1);
   assign trial = {rem_ff, num_ff[QW-1]};
   assign diff = trial - {1'b0, div_ff};
   assign sample_wide = 32'(sample_ff);
   assign total_sat = (sample_wide > 32'(cbfe_pkg::TOTAL_MAX))
                    ? cbfe_pkg::TOTAL_MAX : sample_wide[23:0];
   assign frac_clamped = (quo_ff > cbfe_pkg::FRAC_ONE) ? cbfe_pkg::FRAC_ONE : quo_ff;

   always_comb begin
      busy_in = busy_ff;
      sample_in = sample_ff;
      ms_in = ms_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      empty_in = empty_ff;
      total_in = total_ff;
      if (cmd.sample_en) begin
         if (rssi > cfg.busy_threshold && busy_ff != '1) begin
            busy_in = busy_ff + 1'b1;
         end
         if (sample_ff != '1) begin
            sample_in = sample_ff + 1'b1;
         end
      end
      if (cmd.tick_en) begin
         if (window_end) begin
            // Window closes: snapshot the counters for the divider and restart.
            rem_in = numerator[NumWidth-1:QW];
            num_in = numerator[QW-1:0];
            div_in = sample_ff;
            quo_in = '0;
            empty_in = sample_ff == '0;
            total_in = total_sat;
            busy_in = '0;
            sample_in = '0;
            ms_in = cfg.window_ms;
         end else begin
            ms_in = ms_ff - 1'b1;
         end
      end
      if (cmd.div_step) begin
         num_in = {num_ff[QW-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_in.busy_fraction = empty_ff ? '0 : frac_clamped;
         out_in.empty_window = empty_ff;
         out_in.sample_total = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         sample_ff <= '0;
         ms_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         sample_ff <= sample_in;
         ms_ff <= ms_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      empty_ff <= empty_in;
      total_ff <= total_in;
      out_ff <= out_in;
   end

   assign status.window_end = window_end;
   assign status.empty = sample_ff == '0;
   assign status.out_valid = out_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_ff;

endmodule

// ----- rtl/channel_busy_fraction_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel busy fraction estimator
// Counts busy signal strength samples and reports the busy fraction per window.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one word per item, either a signal strength
// sample (op low) or a one millisecond tick (op high). Samples are taken one
// per cycle while req_ready is high and cost nothing beyond the handshake. A
// tick that does not end a window is taken the same way. A tick that ends a
// window while reporting is enabled starts a serial restoring divider that
// produces one quotient bit per cycle; the block then loads the result into
// the result register once that register is free, or goes straight to the
// load when the window held no samples, and rsp_valid rises after the load.
// While that division and the load run, req_ready is low.
// The rsp channel is fronted by a result register. Samples and ticks keep
// being accepted while a finished result waits; if the receiver stalls and a
// second report completes, the block holds it and stops accepting words until
// the first is taken.
// Reset is synchronous, restores the register defaults (threshold -70 dBm,
// 1000 ms window, reporting off) and clears both counters and the countdown,
// so the first tick after reset ends a window. Registers: APB-style, no wait
// states; the user must write them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module channel_busy_fraction_estimator #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cbfe_pkg::req_type                     req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output cbfe_pkg::rsp_type                     rsp_word,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cbfe_pkg::ADDR_WIDTH-1:0]       paddr,
   input  logic [cbfe_pkg::DATA_WIDTH-1:0]       pwdata,
   output logic [cbfe_pkg::DATA_WIDTH-1:0]       prdata,
   output logic                                  pready
);

   // Register file. The word index is the byte address divided by four.
   cbfe_pkg::cfg_type cfg_ff, cfg_in;
   cbfe_pkg::cmd_type cmd;
   cbfe_pkg::status_type status;
   logic [1:0] reg_index;
   logic write_en;

   assign pready = 1'b1;
   assign reg_index = paddr[3:2];
   assign write_en = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            cbfe_pkg::REG_BUSY_THRESHOLD: cfg_in.busy_threshold = pwdata[11:0];
            cbfe_pkg::REG_WINDOW_MS: cfg_in.window_ms = pwdata[15:0];
            cbfe_pkg::REG_REPORT_ENABLE: cfg_in.report_enable = pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.busy_threshold <= cbfe_pkg::THRESHOLD_RESET;
         cfg_ff.window_ms <= cbfe_pkg::WINDOW_RESET;
         cfg_ff.report_enable <= cbfe_pkg::REPORT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data: the threshold reads back sign extended.
   always_comb begin
      case (reg_index)
         cbfe_pkg::REG_BUSY_THRESHOLD:
            prdata = {{20{cfg_ff.busy_threshold[11]}}, cfg_ff.busy_threshold};
         cbfe_pkg::REG_WINDOW_MS: prdata = {16'd0, cfg_ff.window_ms};
         cbfe_pkg::REG_REPORT_ENABLE: prdata = {31'd0, cfg_ff.report_enable};
         default: prdata = '0;
      endcase
   end

   cbfe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_op        (req_word.op),
      .rsp_ready     (rsp_ready),
      .report_enable (cfg_ff.report_enable),
      .status        (status),
      .req_ready     (req_ready),
      .cmd           (cmd)
   );

   cbfe_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .rssi      (req_word.rssi),
      .rsp_ready (rsp_ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- rtl/cbfe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel busy fraction estimator checker
// Port-level properties of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module cbfe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input cbfe_pkg::req_type  req_word,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input cbfe_pkg::rsp_type  rsp_word
);

   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed or dropped");

   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.busy_fraction <= cbfe_pkg::FRAC_ONE)
      else $error("busy fraction above one");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.empty_window
         |-> rsp_word.busy_fraction == '0 && rsp_word.sample_total == '0)
      else $error("empty window report carries nonzero fields");

   a_sample_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.op == cbfe_pkg::OP_SAMPLE && !rsp_valid
         |=> !rsp_valid)
      else $error("result word appeared right after a sample");

endmodule

bind channel_busy_fraction_estimator cbfe_checker u_cbfe_checker (.*);
